FILE: rtl/core/difficulty_retarget_assert.svh
// Assertion macros for the retarget core.
// Needs nothing else; taken in by the top level with an include.
`ifndef DIFFICULTY_RETARGET_ASSERT_SVH
`define DIFFICULTY_RETARGET_ASSERT_SVH

// Implication in the same cycle, quiet while reset is asserted.
`define DR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication in the next cycle, quiet while reset is asserted.
`define DR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/dr_pkg.sv
// Shared constants, types and fixed-width divide steps of the retarget core.
// No dependencies.
package dr_pkg;

  localparam int unsigned TARGET_WIDTH_DEF = 256;

  localparam int unsigned ITV_W = 16;
  localparam int unsigned TS_W  = 26;
  localparam int unsigned FAC_W = 5;
  localparam int unsigned CMP_W = 32;
  localparam int unsigned SPAN_W = TS_W + FAC_W;

  localparam logic [ITV_W-1:0] ITV_RST = 16'd2016;
  localparam logic [TS_W-1:0]  TS_RST  = 26'd1209600;
  localparam logic [FAC_W-1:0] FAC_RST = 5'd4;
  localparam logic [CMP_W-1:0] LIM_RST = 32'h1f00ffff;

  // Register indexes of the configuration port.
  typedef enum logic [1:0] {
    CFG_INTERVAL = 2'd0,
    CFG_TIMESPAN = 2'd1,
    CFG_FACTOR   = 2'd2,
    CFG_LIMIT    = 2'd3
  } dr_cfg_e;

  // Height modulo interval: 8 stages of 8 steps cover 64 bits.
  localparam int unsigned MOD_STAGES = 8;
  localparam int unsigned MOD_STEPS  = 8;
  // Timespan over factor rides along: 8 stages of 4 steps cover 32 bits.
  localparam int unsigned MS_STEPS   = 4;
  localparam int unsigned MS_W       = 32;
  // Quotient bits per stage of the wide divider.
  localparam int unsigned DIV_STEPS  = 8;

  typedef struct packed {
    logic [ITV_W-1:0] rem;
    logic [63:0]      num;
  } dr_mod_t;

  typedef struct packed {
    logic [FAC_W-1:0] rem;
    logic [MS_W-1:0]  num;
  } dr_ms_t;

  // Restoring remainder steps; the dividend shifts out at the top.
  function automatic dr_mod_t mod_steps(dr_mod_t s, logic [ITV_W-1:0] d);
    dr_mod_t        r;
    logic [ITV_W:0] t;
    r = s;
    for (int i = 0; i < MOD_STEPS; i++) begin
      t = {r.rem, r.num[63]};
      r.num = {r.num[62:0], 1'b0};
      if (t >= {1'b0, d}) begin
        t = t - {1'b0, d};
      end
      r.rem = t[ITV_W-1:0];
    end
    return r;
  endfunction

  // Restoring division steps; quotient bits shift in at the bottom.
  function automatic dr_ms_t ms_steps(dr_ms_t s, logic [FAC_W-1:0] d);
    dr_ms_t         r;
    logic [FAC_W:0] t;
    logic           ge;
    r = s;
    for (int i = 0; i < MS_STEPS; i++) begin
      t = {r.rem, r.num[MS_W-1]};
      ge = (t >= {1'b0, d});
      if (ge) begin
        t = t - {1'b0, d};
      end
      r.rem = t[FAC_W-1:0];
      r.num = {r.num[MS_W-2:0], ge};
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/difficulty_retarget.sv
// Difficulty retarget core: pipelined compact-target scaling.
// Depends on dr_pkg and difficulty_retarget_assert.svh.
//
// One request enters per clock while the pipe is not stalled by the output; the
// new target comes from a restoring divider, which retires eight quotient bits
// per stage, behind eight stages that form height modulo interval. Every stage
// advances together whenever the output register is empty or being taken, so
// a stalled consumer freezes the whole pipe without losing or repeating a
// request. Away from a retarget boundary the parent compact value comes out
// unchanged; at a boundary the elapsed time is clamped to
// [timespan/factor, timespan*factor], the decoded parent target is scaled by
// elapsed/timespan modulo 2^TARGET_WIDTH, capped at the limit target and
// re-encoded. A zero timespan or factor acts as 1 and a zero interval never
// retargets. Write configuration only while the pipe is empty.
module difficulty_retarget #(
  parameter int unsigned TARGET_WIDTH = dr_pkg::TARGET_WIDTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [63:0]        block_height_i,
  input  logic [31:0]        parent_compact_i,
  input  logic signed [63:0] period_first_time_i,
  input  logic signed [63:0] period_last_time_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [31:0]        next_compact_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [31:0]        cfg_wdata_i
);

  localparam int unsigned TW  = TARGET_WIDTH;
  localparam int unsigned NL  = (TW + 31) / 32;          // 32-bit limbs
  localparam int unsigned PW  = 32 * NL;
  localparam int unsigned NB  = (TW + 7) / 8;            // bytes of a target
  localparam int unsigned PB  = 8 * NB;
  localparam int unsigned KW  = $clog2(NB);
  localparam int unsigned SZW = $clog2(NB + 2);
  localparam int unsigned DS  = (TW + dr_pkg::DIV_STEPS - 1) / dr_pkg::DIV_STEPS;
  localparam int unsigned QW  = DS * dr_pkg::DIV_STEPS;
  localparam int unsigned SW  = dr_pkg::SPAN_W;
  localparam int unsigned TSW = dr_pkg::TS_W;

  // Stage map.
  localparam int unsigned ST_IN   = 0;
  localparam int unsigned M_LAST  = ST_IN + dr_pkg::MOD_STAGES;
  localparam int unsigned ST_SPAN = M_LAST + 1;
  localparam int unsigned ST_PP   = ST_SPAN + 1;
  localparam int unsigned ST_SUM  = ST_PP + 1;
  localparam int unsigned ST_D0   = ST_SUM + 1;
  localparam int unsigned D_LAST  = ST_D0 + DS - 1;
  localparam int unsigned ST_LIM  = D_LAST + 1;
  localparam int unsigned ST_E1   = ST_LIM + 1;
  localparam int unsigned ST_E2   = ST_E1 + 1;
  localparam int unsigned ST_OUT  = ST_E2 + 1;
  localparam int unsigned NST     = ST_OUT + 1;

  typedef struct packed {
    logic [TSW-1:0] rem;
    logic [QW-1:0]  num;
  } div_t;

  // Compact to full target; bits at or above TW drop off.
  function automatic logic [TW-1:0] decode(logic [31:0] c);
    logic [7:0]    sz;
    logic [7:0]    sh;
    logic [1:0]    dn;
    logic [22:0]   m;
    logic [TW-1:0] v;
    sz = c[31:24];
    m  = c[22:0];
    sh = sz - 8'd3;
    dn = 2'(8'd3 - sz);
    v  = '0;
    if (sz <= 8'd3) begin
      v = TW'(m >> {dn, 3'b000});
    end else if (sh < 8'(NB)) begin
      v = TW'(m) << {sh[KW-1:0], 3'b000};
    end
    return v;
  endfunction

  function automatic div_t div_steps(div_t s, logic [TSW-1:0] d);
    div_t         r;
    logic [TSW:0] t;
    logic         ge;
    r = s;
    for (int i = 0; i < dr_pkg::DIV_STEPS; i++) begin
      t = {r.rem, r.num[QW-1]};
      ge = (t >= {1'b0, d});
      if (ge) begin
        t = t - {1'b0, d};
      end
      r.rem = t[TSW-1:0];
      r.num = {r.num[QW-2:0], ge};
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Configuration registers and values derived from them
  // ---------------------------------------------------------------------
  logic [dr_pkg::ITV_W-1:0] itv_q;
  logic [TSW-1:0]           ts_q;
  logic [dr_pkg::FAC_W-1:0] fac_q;
  logic [31:0]              lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      itv_q <= dr_pkg::ITV_RST;
      ts_q  <= dr_pkg::TS_RST;
      fac_q <= dr_pkg::FAC_RST;
      lim_q <= dr_pkg::LIM_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dr_pkg::CFG_INTERVAL: itv_q <= cfg_wdata_i[dr_pkg::ITV_W-1:0];
        dr_pkg::CFG_TIMESPAN: ts_q  <= cfg_wdata_i[TSW-1:0];
        dr_pkg::CFG_FACTOR:   fac_q <= cfg_wdata_i[dr_pkg::FAC_W-1:0];
        dr_pkg::CFG_LIMIT:    lim_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Zero timespan and zero factor both act as one.
  logic [TSW-1:0]           ts_eff;
  logic [dr_pkg::FAC_W-1:0] fac_eff;
  assign ts_eff  = (ts_q == '0) ? TSW'(1) : ts_q;
  assign fac_eff = (fac_q == '0) ? dr_pkg::FAC_W'(1) : fac_q;

  // The user must let configuration move only while the pipe is empty; the block
  // does not enforce it. Then no request sees these registered copies stale.
  logic [TSW-1:0]           ts_eff_q;
  logic [dr_pkg::FAC_W-1:0] fac_eff_q;
  logic [SW-1:0]            maxspan_q;
  logic [TW-1:0]            lim_dec_q;

  always_ff @(posedge clk_i) begin
    ts_eff_q  <= ts_eff;
    fac_eff_q <= fac_eff;
    maxspan_q <= SW'(ts_eff) * SW'(fac_eff);
    lim_dec_q <= decode(lim_q);
  end

  // ---------------------------------------------------------------------
  // Pipeline control: one shared advance, valid bits shift with the data
  // ---------------------------------------------------------------------
  logic [NST-1:0] vld_q;
  logic           adv;

  assign adv         = !vld_q[ST_OUT] || out_ready_i;
  assign in_ready_o  = adv;
  assign out_valid_o = vld_q[ST_OUT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NST-2:0], in_valid_i};
    end
  end

  // ---------------------------------------------------------------------
  // Stage payload
  // ---------------------------------------------------------------------
  logic [31:0]     pass_q  [ST_IN:ST_E2];
  logic [64:0]     diff_q  [ST_IN:M_LAST];
  dr_pkg::dr_mod_t mod_q   [ST_IN:M_LAST];
  dr_pkg::dr_ms_t  ms_q    [ST_IN:M_LAST];
  logic [ST_OUT:ST_SPAN] rt_q;
  logic [SW-1:0]   span_q;
  logic [TW-1:0]   tgt_q;
  logic [62:0]     pp_q    [NL];
  div_t            div_q   [ST_SUM:D_LAST];
  logic [TW-1:0]   tgt_lim_q;
  logic [TW-1:0]   tgt_e_q;
  logic [NB-1:0]   nzb_q;
  logic [SZW-1:0]  sz_q;
  logic [23:0]     mant_q;
  logic [31:0]     out_q;

  // Exact elapsed time, one bit wider so it never wraps.
  logic signed [64:0] diff_in;
  assign diff_in = 65'(period_last_time_i) - 65'(period_first_time_i);

  // Divide steps between stages.
  dr_pkg::dr_mod_t mod_d [ST_IN+1:M_LAST];
  dr_pkg::dr_ms_t  ms_d  [ST_IN+1:M_LAST];
  div_t            div_d [ST_D0:D_LAST];

  always_comb begin
    for (int k = ST_IN + 1; k <= M_LAST; k++) begin
      mod_d[k] = dr_pkg::mod_steps(mod_q[k-1], itv_q);
      ms_d[k]  = dr_pkg::ms_steps(ms_q[k-1], fac_eff_q);
    end
    for (int k = ST_D0; k <= D_LAST; k++) begin
      div_d[k] = div_steps(div_q[k-1], ts_eff_q);
    end
  end

  // Clamp the elapsed time; a negative span takes the lower bound.
  logic [TSW-1:0] minspan;
  logic [64:0]    diff_m;
  logic [SW-1:0]  span_d;
  logic           rt_d;

  assign minspan = ms_q[M_LAST].num[TSW-1:0];
  assign diff_m  = diff_q[M_LAST];
  assign rt_d    = (itv_q != '0) && (mod_q[M_LAST].rem == '0);

  always_comb begin
    if (diff_m[64] || (diff_m[63:0] < 64'(minspan))) begin
      span_d = SW'(minspan);
    end else if (diff_m[63:0] > 64'(maxspan_q)) begin
      span_d = maxspan_q;
    end else begin
      span_d = diff_m[SW-1:0];
    end
  end

  // Partial products per limb, then one wide add that drops carries past TW.
  logic [PW-1:0] tgt_pw;
  logic [PW-1:0] sum_lo;
  logic [PW-1:0] sum_hi;
  logic [TW-1:0] prod;

  assign tgt_pw = PW'(tgt_q);

  always_comb begin
    sum_lo = '0;
    sum_hi = '0;
    for (int i = 0; i < NL; i++) begin
      sum_lo[32*i +: 32] = pp_q[i][31:0];
    end
    for (int i = 0; i + 1 < NL; i++) begin
      sum_hi[32*(i+1) +: 31] = pp_q[i][62:32];
    end
  end

  assign prod = TW'(sum_lo + sum_hi);

  // Encode: find the top nonzero byte, take it and the two bytes below it.
  logic [TW-1:0]  quot;
  logic [PB-1:0]  tpad;
  logic [NB-1:0]  nzb_d;
  logic [SZW-1:0] sz_d;
  logic [23:0]    mant_d;
  logic [SZW-1:0] sz_n;
  logic [23:0]    mant_n;
  logic [31:0]    compact;

  assign quot = div_q[D_LAST].num[TW-1:0];

  always_comb begin
    for (int j = 0; j < NB; j++) begin
      nzb_d[j] = |(PB'(tgt_lim_q) >> (8 * j) & PB'(8'hff));
    end
  end

  assign tpad = PB'(tgt_e_q);

  always_comb begin
    sz_d = '0;
    for (int j = 0; j < NB; j++) begin
      if (nzb_q[j]) begin
        sz_d = SZW'(j + 1);
      end
    end
  end

  assign mant_d  = 24'({tpad, 24'h000000} >> {sz_d, 3'b000});
  // Keep the sign bit clear: move up one byte when the top bit is set.
  assign sz_n    = sz_q + SZW'(mant_q[23]);
  assign mant_n  = mant_q[23] ? {8'h00, mant_q[23:8]} : mant_q;
  assign compact = {8'(sz_n), mant_n};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      // Input stage.
      pass_q[ST_IN]      <= parent_compact_i;
      diff_q[ST_IN]      <= diff_in;
      mod_q[ST_IN].rem   <= '0;
      mod_q[ST_IN].num   <= block_height_i;
      ms_q[ST_IN].rem    <= '0;
      ms_q[ST_IN].num    <= dr_pkg::MS_W'(ts_eff);

      // Height modulo interval and timespan over factor.
      for (int k = ST_IN + 1; k <= M_LAST; k++) begin
        pass_q[k] <= pass_q[k-1];
        diff_q[k] <= diff_q[k-1];
        mod_q[k]  <= mod_d[k];
        ms_q[k]   <= ms_d[k];
      end

      // Clamp and decode.
      pass_q[ST_SPAN] <= pass_q[M_LAST];
      rt_q[ST_SPAN]   <= rt_d;
      span_q          <= span_d;
      tgt_q           <= decode(pass_q[M_LAST]);

      // Hold the flag and the parent alongside everything after.
      for (int k = ST_SPAN + 1; k <= ST_E2; k++) begin
        pass_q[k] <= pass_q[k-1];
      end
      for (int k = ST_SPAN + 1; k <= ST_OUT; k++) begin
        rt_q[k] <= rt_q[k-1];
      end

      for (int i = 0; i < NL; i++) begin
        pp_q[i] <= 63'(tgt_pw[32*i +: 32]) * 63'(span_q);
      end

      div_q[ST_SUM].rem <= '0;
      div_q[ST_SUM].num <= QW'(prod);
      for (int k = ST_D0; k <= D_LAST; k++) begin
        div_q[k] <= div_d[k];
      end

      tgt_lim_q <= (quot > lim_dec_q) ? lim_dec_q : quot;

      tgt_e_q <= tgt_lim_q;
      nzb_q   <= nzb_d;

      sz_q   <= sz_d;
      mant_q <= mant_d;

      out_q <= rt_q[ST_E2] ? compact : pass_q[ST_E2];
    end
  end

  assign next_compact_o = out_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
`include "difficulty_retarget_assert.svh"

  `DR_ASSERT_IMP(a_span_max, clk_i, rst_ni, vld_q[ST_SPAN] && rt_q[ST_SPAN], span_q <= maxspan_q, "clamped span above upper bound")
  `DR_ASSERT_IMP(a_lim_cap, clk_i, rst_ni, vld_q[ST_LIM], tgt_lim_q <= lim_dec_q, "target above limit after cap")
  `DR_ASSERT_NXT(a_hold, clk_i, rst_ni, !adv, $stable(vld_q), "pipe moved during a stall")
  `DR_ASSERT_IMP(a_sign, clk_i, rst_ni, vld_q[ST_OUT] && rt_q[ST_OUT], !next_compact_o[23], "encoded target has sign bit set")

endmodule
